// ----- sv/psc_pkg.sv -----
`default_nettype none

package psc_pkg;

    // default sizes of the bitmap store
    localparam int ITEMS_DEF = 256;
    localparam int WORDS_DEF = 256;

    // field widths
    localparam int ITEM_W    = 8;
    localparam int WIDX_W    = 8;
    localparam int WORD_W    = 16;
    localparam int SUP_W     = 13;
    localparam int WIU_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SUPPORT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS_IN_USE = 2'd1;

    // configuration reset values
    localparam logic [SUP_W-1:0] MIN_SUPPORT_RST  = 13'd0;
    localparam logic [WIU_W-1:0] WORDS_IN_USE_RST = 9'd256;

    // saturation limit of the support count
    localparam logic [SUP_W-1:0] SUPPORT_MAX = 13'd8191;

    // query sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } psc_state_t;

endpackage

`default_nettype wire

// ----- sv/psc_bitmap_mem.sv -----
`default_nettype none

module psc_bitmap_mem
    import psc_pkg::*;
#(
    parameter int ITEMS = ITEMS_DEF,
    parameter int WORDS = WORDS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               wr_en,
    input  wire logic [$clog2(ITEMS)-1:0]           wr_item,
    input  wire logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] wr_word,
    input  wire logic [WORD_W-1:0]                  wr_data,
    input  wire logic [$clog2(ITEMS)-1:0]           rd_item_a,
    input  wire logic [$clog2(ITEMS)-1:0]           rd_item_b,
    input  wire logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] rd_word,
    output logic      [WORD_W-1:0]                  rd_data_a,
    output logic      [WORD_W-1:0]                  rd_data_b
);

    localparam int IW    = $clog2(ITEMS);
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int AW    = IW + WW;
    localparam int DEPTH = 1 << AW;

    // one row of 2**WW words per item
    logic [WORD_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_item, wr_word}] <= wr_data;
        end
    end

    // two registered read ports, same word of both items
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[{rd_item_a, rd_word}];
        rd_data_b <= mem[{rd_item_b, rd_word}];
    end

endmodule

`default_nettype wire

// ----- sv/pairwise_support_count_unit.sv -----
`default_nettype none

// Pairwise support counter over per-item transaction bitmaps held in one
// on-chip memory with two read ports. A write item (command 0) stores one
// 16-bit bitmap word and gives no result. A query item (command 1) ANDs the
// bitmaps of item_a and item_b over n = min(words_in_use, WORDS) words and
// counts the set bits; one word pair is read per cycle, and no new item is
// taken until the query is done. When n is zero or an item is out of range, no
// word is read. The support saturates at 8191 and frequent is set when
// support >= min_support. The finished result waits in an output register, so
// further items are taken while it is not yet collected. The store has no
// reset and needs no clearing pass: every word a query reads must have been
// written first. Configuration is always ready and must be written while the
// block is idle.
module pairwise_support_count_unit
    import psc_pkg::*;
#(
    parameter int ITEMS = ITEMS_DEF,
    parameter int WORDS = WORDS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 command,
    input  wire logic [ITEM_W-1:0]    item_a,
    input  wire logic [ITEM_W-1:0]    item_b,
    input  wire logic [WIDX_W-1:0]    word_index,
    input  wire logic [WORD_W-1:0]    word_data,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [SUP_W-1:0]     support,
    output logic                      frequent,
    // configuration channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int IW   = $clog2(ITEMS);
    localparam int WW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNTW = 13;
    localparam int PCW  = $clog2(WORD_W + 1);

    localparam logic [CNTW-1:0] ITEMS_C = CNTW'(ITEMS);
    localparam logic [CNTW-1:0] WORDS_C = CNTW'(WORDS);

    // count of set bits in one word
    function automatic logic [PCW-1:0] ones16(input logic [WORD_W-1:0] v);
        logic [PCW-1:0] n;
        n = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            n = n + PCW'(v[i]);
        end
        return n;
    endfunction

    psc_state_t state_reg, state_next;

    logic [SUP_W-1:0] min_support_reg;
    logic [WIU_W-1:0] words_in_use_reg;

    logic [IW-1:0]    item_a_reg, item_a_next;
    logic [IW-1:0]    item_b_reg, item_b_next;
    logic [CNTW-1:0]  n_reg, n_next;
    logic [CNTW-1:0]  k_reg, k_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [SUP_W-1:0] acc_reg, acc_next;
    logic             out_valid_reg, out_valid_next;
    logic [SUP_W-1:0] support_reg, support_next;
    logic             frequent_reg, frequent_next;

    logic             in_accept;
    logic             out_load;
    logic [CNTW-1:0]  item_a_ext, item_b_ext, word_ext, words_ext, n_clamp;
    logic             wr_en;
    logic [WORD_W-1:0] rd_data_a, rd_data_b;
    logic [SUP_W:0]   acc_sum;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign support   = support_reg;
    assign frequent  = frequent_reg;

    // range checks and word count clamp
    assign item_a_ext = CNTW'(item_a);
    assign item_b_ext = CNTW'(item_b);
    assign word_ext   = CNTW'(word_index);
    assign words_ext  = CNTW'(words_in_use_reg);
    assign n_clamp    = (words_ext > WORDS_C) ? WORDS_C : words_ext;

    assign wr_en = in_accept && (command == CMD_WRITE)
                   && (item_a_ext < ITEMS_C) && (word_ext < WORDS_C);

    psc_bitmap_mem #(
        .ITEMS (ITEMS),
        .WORDS (WORDS)
    ) u_mem (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_item   (item_a_ext[IW-1:0]),
        .wr_word   (word_ext[WW-1:0]),
        .wr_data   (word_data),
        .rd_item_a (item_a_reg),
        .rd_item_b (item_b_reg),
        .rd_word   (k_reg[WW-1:0]),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // saturating accumulate of the AND popcount
    assign acc_sum = {1'b0, acc_reg} + (SUP_W + 1)'(ones16(rd_data_a & rd_data_b));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_support_reg  <= MIN_SUPPORT_RST;
            words_in_use_reg <= WORDS_IN_USE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_SUPPORT:  min_support_reg  <= cfg_data;
                CFG_WORDS_IN_USE: words_in_use_reg <= cfg_data[WIU_W-1:0];
                default:          ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        item_a_next    = item_a_reg;
        item_b_next    = item_b_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rd_valid_next  = 1'b0;
        acc_next       = acc_reg;
        support_next   = support_reg;
        frequent_next  = frequent_reg;
        out_load       = 1'b0;

        if (rd_valid_reg)
        begin
            acc_next = (acc_sum > (SUP_W + 1)'(SUPPORT_MAX)) ? SUPPORT_MAX
                                                            : acc_sum[SUP_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (command == CMD_QUERY))
                begin
                    item_a_next = item_a_ext[IW-1:0];
                    item_b_next = item_b_ext[IW-1:0];
                    n_next      = n_clamp;
                    k_next      = '0;
                    acc_next    = '0;
                    if ((item_a_ext < ITEMS_C) && (item_b_ext < ITEMS_C)
                        && (n_clamp != '0))
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_RUN:
            begin
                rd_valid_next = 1'b1;
                k_next        = k_reg + 1'b1;
                if (k_reg == n_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load      = 1'b1;
                    support_next  = acc_reg;
                    frequent_next = (acc_reg >= min_support_reg);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        item_a_reg   <= item_a_next;
        item_b_reg   <= item_b_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        support_reg  <= support_next;
        frequent_reg <= frequent_next;
    end

    // read data is only counted in the cycle after a read cycle
    a_rd_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == S_RUN))
        else $error("read data counted without a read cycle");

    // the word counter never passes the words in use
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (k_reg < n_reg))
        else $error("word counter beyond words in use");

    // leaving the done state always presents a result
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> out_valid_reg)
        else $error("finished query produced no result");

endmodule

`default_nettype wire
